FILE: rtl/core/dtpq_pkg.sv
// shared constants for the deadline timer priority queue
// command and result kind codes, default sizes; no dependencies
package dtpq_pkg;

   localparam int CAPACITY_DEF    = 32;
   localparam int TIME_BITS_DEF   = 48;
   localparam int HANDLE_BITS_DEF = 16;

   localparam int CMD_W   = 3;
   localparam int KIND_W  = 3;
   localparam int COUNT_W = 6;
   localparam int SEQ_W   = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SCHED_AT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SCHED_AFTER = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DRAIN       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CANCEL      = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd4;

endpackage

FILE: rtl/core/dtpq_if.sv
// request and response channel interfaces of the timer queue
// depends on dtpq_pkg for field widths
interface dtpq_req_if #(
   parameter int TIME_BITS   = dtpq_pkg::TIME_BITS_DEF,
   parameter int HANDLE_BITS = dtpq_pkg::HANDLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [dtpq_pkg::CMD_W-1:0]    cmd;
   logic [HANDLE_BITS-1:0]        handle_id;
   logic                          handle_live;
   logic [TIME_BITS-1:0]          deadline;
   logic signed [TIME_BITS-1:0]   delay;
   logic [TIME_BITS-1:0]          now;

   modport source (output valid, cmd, handle_id, handle_live, deadline, delay, now,
                   input ready);
   modport sink   (input valid, cmd, handle_id, handle_live, deadline, delay, now,
                   output ready);
endinterface

interface dtpq_rsp_if #(
   parameter int TIME_BITS   = dtpq_pkg::TIME_BITS_DEF,
   parameter int HANDLE_BITS = dtpq_pkg::HANDLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [dtpq_pkg::KIND_W-1:0]   kind;
   logic [HANDLE_BITS-1:0]        handle;
   logic [TIME_BITS-1:0]          wait_time;
   logic                          has_next;
   logic [dtpq_pkg::COUNT_W-1:0]  count;
   logic                          accepted;
   logic                          last;

   modport source (output valid, kind, handle, wait_time, has_next, count, accepted, last,
                   input ready);
   modport sink   (input valid, kind, handle, wait_time, has_next, count, accepted, last,
                   output ready);
endinterface

FILE: rtl/core/deadline_timer_priority_queue_core.sv
// deadline timer priority queue, top level: binary min-heap in one memory
// depends on dtpq_pkg, dtpq_if, dtpq_heap_mem
//
//   channel | dir | beat
//   req     | in  | one command: cmd, handle_id, handle_live, deadline, delay, now
//   rsp     | out | one result item; last marks the final item of a command
//
// one command at a time; req.ready is high only while idle
// ready returns when the final result of a command is registered
// schedule: climb the heap level by level, read the parent, compare, write
// drain or cancel: per entry, read the root and the last entry, then sift down
// reading the children; query reads the root; all reads share one read port
// synchronous reset empties the heap at once through the occupancy count
// a stalled rsp holds the sequencer at its next result; nothing is lost
module deadline_timer_priority_queue_core #(
   parameter int CAPACITY    = dtpq_pkg::CAPACITY_DEF,
   parameter int TIME_BITS   = dtpq_pkg::TIME_BITS_DEF,
   parameter int HANDLE_BITS = dtpq_pkg::HANDLE_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   dtpq_req_if.sink   req,
   dtpq_rsp_if.source rsp
);

   localparam int IW  = $clog2(CAPACITY);
   localparam int OW  = $clog2(CAPACITY + 1);
   localparam int CW  = IW + 2;
   localparam int KW  = TIME_BITS + dtpq_pkg::SEQ_W;
   localparam int EW  = KW + HANDLE_BITS;
   localparam int CNW = dtpq_pkg::COUNT_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_UP    = 4'd1;
   localparam logic [3:0] ST_UPCMP = 4'd2;
   localparam logic [3:0] ST_ACK   = 4'd3;
   localparam logic [3:0] ST_LOOP  = 4'd4;
   localparam logic [3:0] ST_ROOT  = 4'd5;
   localparam logic [3:0] ST_PLAST = 4'd6;
   localparam logic [3:0] ST_DNL   = 4'd7;
   localparam logic [3:0] ST_DNR   = 4'd8;
   localparam logic [3:0] ST_DNCMP = 4'd9;
   localparam logic [3:0] ST_DNDEC = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;
   localparam logic [3:0] ST_QANS  = 4'd12;

   logic [3:0]                   state_ff, state_in;
   logic [dtpq_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [TIME_BITS-1:0]         now_ff, now_in;
   logic [EW-1:0]                new_ff, new_in;
   logic [EW-1:0]                hold_ff, hold_in;
   logic [EW-1:0]                child_ff, child_in;
   logic [IW-1:0]                pos_ff, pos_in;
   logic [IW-1:0]                cidx_ff, cidx_in;
   logic [OW-1:0]                occ_ff, occ_in;
   logic [OW-1:0]                cnt_ff, cnt_in;
   logic [dtpq_pkg::SEQ_W-1:0]   seq_ff, seq_in;
   logic                         stopped_ff, stopped_in;
   logic                         acc_ff, acc_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dtpq_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_BITS-1:0]       rsp_handle_ff, rsp_handle_in;
   logic [TIME_BITS-1:0]         rsp_wait_ff, rsp_wait_in;
   logic                         rsp_has_ff, rsp_has_in;
   logic [CNW-1:0]               rsp_count_ff, rsp_count_in;
   logic                         rsp_acc_ff, rsp_acc_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         wr_en, rd_en;
   logic [IW-1:0]                wr_addr, rd_addr;
   logic [EW-1:0]                wr_data, rd_data;

   logic                         out_free;
   logic [TIME_BITS-1:0]         delay_pos;
   logic [TIME_BITS:0]           dl_sum;
   logic [TIME_BITS-1:0]         dl_after;
   logic [CW-1:0]                left_w, right_w, occ_w;
   logic [IW-1:0]                parent;
   logic [TIME_BITS-1:0]         rd_deadline;

   dtpq_heap_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (EW),
      .AW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register
   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = rsp_kind_ff;
   assign rsp.handle    = rsp_handle_ff;
   assign rsp.wait_time = rsp_wait_ff;
   assign rsp.has_next  = rsp_has_ff;
   assign rsp.count     = rsp_count_ff;
   assign rsp.accepted  = rsp_acc_ff;
   assign rsp.last      = rsp_last_ff;
   assign req.ready     = (state_ff == ST_IDLE);

   // relative deadline: clamp negative delay, saturate the sum
   assign delay_pos = req.delay[TIME_BITS-1] ? '0 : req.delay;
   assign dl_sum    = {1'b0, req.now} + {1'b0, delay_pos};
   assign dl_after  = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

   // heap index arithmetic
   assign left_w      = {1'b0, pos_ff, 1'b1};
   assign right_w     = left_w + CW'(1);
   assign occ_w       = CW'(occ_ff);
   assign parent      = IW'((pos_ff - IW'(1)) >> 1);
   assign rd_deadline = rd_data[EW-1 -: TIME_BITS];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      new_in        = new_ff;
      hold_in       = hold_ff;
      child_in      = child_ff;
      pos_in        = pos_ff;
      cidx_in       = cidx_ff;
      occ_in        = occ_ff;
      cnt_in        = cnt_ff;
      seq_in        = seq_ff;
      stopped_in    = stopped_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = new_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cmd_in = req.cmd;
               now_in = req.now;
               cnt_in = '0;
               new_in = {(req.cmd == dtpq_pkg::CMD_SCHED_AFTER) ? dl_after : req.deadline,
                         seq_ff, req.handle_id};
               acc_in = !stopped_ff && req.handle_live && (occ_ff != OW'(CAPACITY));
               pos_in = IW'(occ_ff);
               case (req.cmd)
                  dtpq_pkg::CMD_SCHED_AT, dtpq_pkg::CMD_SCHED_AFTER: begin
                     if (!stopped_ff && req.handle_live && (occ_ff != OW'(CAPACITY))) begin
                        state_in = ST_UP;
                     end else begin
                        state_in = ST_ACK;
                     end
                  end
                  dtpq_pkg::CMD_DRAIN: state_in = ST_LOOP;
                  dtpq_pkg::CMD_CANCEL: begin
                     stopped_in = 1'b1;
                     state_in   = ST_LOOP;
                  end
                  dtpq_pkg::CMD_QUERY: begin
                     rd_en    = 1'b1;
                     state_in = ST_QANS;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // sift up: climb while the new entry leaves before its parent
         ST_UP: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               occ_in   = occ_ff + OW'(1);
               seq_in   = seq_ff + dtpq_pkg::SEQ_W'(1);
               state_in = ST_ACK;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent;
               state_in = ST_UPCMP;
            end
         end

         ST_UPCMP: begin
            wr_en = 1'b1;
            if (new_ff[EW-1 -: KW] < rd_data[EW-1 -: KW]) begin
               wr_data  = rd_data;
               pos_in   = parent;
               state_in = ST_UP;
            end else begin
               occ_in   = occ_ff + OW'(1);
               seq_in   = seq_ff + dtpq_pkg::SEQ_W'(1);
               state_in = ST_ACK;
            end
         end

         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dtpq_pkg::KIND_ACK;
               rsp_handle_in = new_ff[HANDLE_BITS-1:0];
               rsp_wait_in   = '0;
               rsp_has_in    = 1'b0;
               rsp_count_in  = CNW'(occ_ff);
               rsp_acc_in    = acc_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         // drain or cancel: look at the root
         ST_LOOP: begin
            if (occ_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_ROOT;
            end
         end

         ST_ROOT: begin
            if (cmd_ff == dtpq_pkg::CMD_DRAIN && rd_deadline > now_ff) begin
               state_in = ST_DONE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = (cmd_ff == dtpq_pkg::CMD_DRAIN) ? dtpq_pkg::KIND_EXPIRED
                                                               : dtpq_pkg::KIND_CANCEL;
               rsp_handle_in = rd_data[HANDLE_BITS-1:0];
               rsp_wait_in   = '0;
               rsp_has_in    = 1'b0;
               rsp_count_in  = '0;
               rsp_acc_in    = 1'b0;
               rsp_last_in   = 1'b0;
               cnt_in        = cnt_ff + OW'(1);
               rd_en         = 1'b1;
               rd_addr       = IW'(occ_ff - OW'(1));
               occ_in        = occ_ff - OW'(1);
               state_in      = ST_PLAST;
            end
         end

         ST_PLAST: begin
            hold_in  = rd_data;
            pos_in   = '0;
            state_in = ST_DNL;
         end

         // sift down: the last entry falls from the root
         ST_DNL: begin
            if (left_w >= occ_w) begin
               wr_en    = 1'b1;
               wr_data  = hold_ff;
               state_in = ST_LOOP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IW'(left_w);
               state_in = ST_DNR;
            end
         end

         ST_DNR: begin
            child_in = rd_data;
            cidx_in  = IW'(left_w);
            if (right_w < occ_w) begin
               rd_en    = 1'b1;
               rd_addr  = IW'(right_w);
               state_in = ST_DNCMP;
            end else begin
               state_in = ST_DNDEC;
            end
         end

         ST_DNCMP: begin
            if (rd_data[EW-1 -: KW] < child_ff[EW-1 -: KW]) begin
               child_in = rd_data;
               cidx_in  = IW'(right_w);
            end
            state_in = ST_DNDEC;
         end

         ST_DNDEC: begin
            wr_en = 1'b1;
            if (child_ff[EW-1 -: KW] < hold_ff[EW-1 -: KW]) begin
               wr_data  = child_ff;
               pos_in   = cidx_ff;
               state_in = ST_DNL;
            end else begin
               wr_data  = hold_ff;
               state_in = ST_LOOP;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = (cmd_ff == dtpq_pkg::CMD_DRAIN) ? dtpq_pkg::KIND_DONE
                                                               : dtpq_pkg::KIND_CANCEL;
               rsp_handle_in = '0;
               rsp_wait_in   = '0;
               rsp_has_in    = 1'b0;
               rsp_count_in  = CNW'(cnt_ff);
               rsp_acc_in    = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_QANS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dtpq_pkg::KIND_NEXT;
               rsp_handle_in = '0;
               rsp_wait_in   = (occ_ff != '0 && rd_deadline > now_ff) ? rd_deadline - now_ff
                                                                      : '0;
               rsp_has_in    = (occ_ff != '0);
               rsp_count_in  = CNW'(occ_ff);
               rsp_acc_in    = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         seq_ff       <= dtpq_pkg::SEQ_W'(1);
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         seq_ff       <= seq_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      new_ff        <= new_in;
      hold_ff       <= hold_in;
      child_ff      <= child_in;
      pos_ff        <= pos_in;
      cidx_ff       <= cidx_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

FILE: rtl/core/dtpq_heap_mem.sv
// heap storage: one write port, one read port, registered read data
// no dependencies
module dtpq_heap_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 96,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: dv/dtpq_tb_if.sv
// testbench-side note: the channel interfaces come from rtl/core/dtpq_if.sv
// this file holds the channel activity monitor used by the testbench
// no dependencies; it takes plain valid and ready signals
module dtpq_beat_monitor (
   input logic clock,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   output int  req_beats,
   output int  rsp_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   // count accepted beats on both channels
   initial begin
      req_beats = 0;
      rsp_beats = 0;
   end
   always @(posedge clock) begin
      if (req_valid && req_ready) req_beats <= req_beats + 1;
      if (rsp_valid && rsp_ready) rsp_beats <= rsp_beats + 1;
   end
endmodule

FILE: dv/testbench.sv
// testbench for deadline_timer_priority_queue_core: directed and random commands
// checked against a sorted-queue predictor; depends on dtpq_pkg, dtpq_if, the rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 32;
   localparam int TB  = 48;
   localparam logic [TB-1:0] TMAX = {TB{1'b1}};

   typedef struct packed {
      logic [dtpq_pkg::KIND_W-1:0]  kind;
      logic [15:0]                  handle;
      logic [TB-1:0]                wait_time;
      logic                         has_next;
      logic [dtpq_pkg::COUNT_W-1:0] count;
      logic                         accepted;
      logic                         last;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   dtpq_req_if #(TB, 16) req_ch ();
   dtpq_rsp_if #(TB, 16) rsp_ch ();

   deadline_timer_priority_queue_core #(CAP, TB, 16) i_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   int req_beats, rsp_beats;
   dtpq_beat_monitor i_mon (
      .clock(clock), .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .req_beats(req_beats), .rsp_beats(rsp_beats)
   );

   // predictor state: queue kept sorted in leave order
   logic [TB-1:0] q_deadline[$];
   logic [31:0]   q_seq[$];
   logic [15:0]   q_handle[$];
   logic [31:0]   seq_ctr = 1;
   logic          halted = 0;
   result_type    expected_results[$];
   int            errors = 0;
   int            send_idle_pct = 0, recv_idle_pct = 0;
   bit            recv_hold = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #50ms;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic result_type mk(logic [dtpq_pkg::KIND_W-1:0] k, logic [15:0] h,
                                     logic [TB-1:0] w, logic hn,
                                     logic [dtpq_pkg::COUNT_W-1:0] c, logic a, logic l);
      result_type r;
      r.kind = k; r.handle = h; r.wait_time = w; r.has_next = hn;
      r.count = c; r.accepted = a; r.last = l;
      return r;
   endfunction

   // work out the results of one command and update the predictor
   task automatic predict_timer_cmd(logic [dtpq_pkg::CMD_W-1:0] cmd, logic [15:0] hid,
                                    logic live, logic [TB-1:0] dl,
                                    logic signed [TB-1:0] dly, logic [TB-1:0] now);
      logic [TB:0]   sum;
      logic [TB-1:0] d;
      logic [TB-1:0] w;
      int            pos, cnt;
      logic          ok;
      cnt = 0;
      case (cmd)
         dtpq_pkg::CMD_SCHED_AT, dtpq_pkg::CMD_SCHED_AFTER: begin
            d = dl;
            if (cmd == dtpq_pkg::CMD_SCHED_AFTER) begin
               sum = {1'b0, now} + {1'b0, (dly < 0) ? {TB{1'b0}} : dly};
               d = sum[TB] ? TMAX : sum[TB-1:0];
            end
            ok = !halted && live && q_deadline.size() < CAP;
            if (ok) begin
               // equal keys never occur except on sequence wrap; insert after equals
               pos = q_deadline.size();
               while (pos > 0 && (d < q_deadline[pos-1] ||
                      (d == q_deadline[pos-1] && seq_ctr < q_seq[pos-1])))
                  pos--;
               q_deadline.insert(pos, d);
               q_seq.insert(pos, seq_ctr);
               q_handle.insert(pos, hid);
               seq_ctr++;
            end
            expected_results.push_back(mk(dtpq_pkg::KIND_ACK, hid, '0, 1'b0,
                                          dtpq_pkg::COUNT_W'(q_deadline.size()), ok, 1'b1));
         end
         dtpq_pkg::CMD_DRAIN: begin
            while (q_deadline.size() > 0 && q_deadline[0] <= now) begin
               expected_results.push_back(mk(dtpq_pkg::KIND_EXPIRED, q_handle[0], '0, 1'b0,
                                             '0, 1'b0, 1'b0));
               void'(q_deadline.pop_front()); void'(q_seq.pop_front());
               void'(q_handle.pop_front());
               cnt++;
            end
            expected_results.push_back(mk(dtpq_pkg::KIND_DONE, '0, '0, 1'b0,
                                          dtpq_pkg::COUNT_W'(cnt), 1'b0, 1'b1));
         end
         dtpq_pkg::CMD_QUERY: begin
            w = '0;
            if (q_deadline.size() > 0 && q_deadline[0] > now) w = q_deadline[0] - now;
            expected_results.push_back(mk(dtpq_pkg::KIND_NEXT, '0, w, q_deadline.size() > 0,
                                          dtpq_pkg::COUNT_W'(q_deadline.size()),
                                          1'b0, 1'b1));
         end
         dtpq_pkg::CMD_CANCEL: begin
            halted = 1;
            while (q_deadline.size() > 0) begin
               expected_results.push_back(mk(dtpq_pkg::KIND_CANCEL, q_handle[0], '0, 1'b0,
                                             '0, 1'b0, 1'b0));
               void'(q_deadline.pop_front()); void'(q_seq.pop_front());
               void'(q_handle.pop_front());
               cnt++;
            end
            expected_results.push_back(mk(dtpq_pkg::KIND_CANCEL, '0, '0, 1'b0,
                                          dtpq_pkg::COUNT_W'(cnt), 1'b0, 1'b1));
         end
         default: ;
      endcase
   endtask

   // send one command beat and predict it on acceptance
   task automatic send_cmd(logic [dtpq_pkg::CMD_W-1:0] cmd, logic [15:0] hid, logic live,
                           logic [TB-1:0] dl, logic signed [TB-1:0] dly, logic [TB-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.cmd <= cmd; req_ch.handle_id <= hid;
      req_ch.handle_live <= live; req_ch.deadline <= dl; req_ch.delay <= dly;
      req_ch.now <= now;
      // ready is sampled as it stood at the edge
      @(posedge clock iff req_ch.ready);
      predict_timer_cmd(cmd, hid, live, dl, dly, now);
   endtask

   task automatic wait_results_drained();
      int guard;
      req_ch.valid <= 0;
      guard = 0;
      while (expected_results.size() > 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [TB-1:0] rand_time();
      return TB'({$urandom, $urandom});
   endfunction

   // response side: random stall and compare
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      result_type got, exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = mk(rsp_ch.kind, rsp_ch.handle, rsp_ch.wait_time, rsp_ch.has_next,
                  rsp_ch.count, rsp_ch.accepted, rsp_ch.last);
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (got !== exp_r) begin
               $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
               errors++;
            end
         end
      end
   end

   // extremes, both schedule forms, drain, query, unknown commands
   task automatic test_directed();
      send_cmd(dtpq_pkg::CMD_QUERY, 0, 0, 0, 0, 0);
      send_cmd(dtpq_pkg::CMD_DRAIN, 0, 0, 0, 0, TMAX);
      send_cmd(dtpq_pkg::CMD_SCHED_AT, 16'hffff, 1, TMAX, 0, 0);
      send_cmd(dtpq_pkg::CMD_SCHED_AT, 16'h0000, 1, 0, 0, 0);
      send_cmd(dtpq_pkg::CMD_SCHED_AT, 16'h1234, 0, 5, 0, 0);
      send_cmd(dtpq_pkg::CMD_SCHED_AFTER, 16'h00aa, 1, 0, -48'sd100, 48'd1000);
      send_cmd(dtpq_pkg::CMD_SCHED_AFTER, 16'h00bb, 1, 0, {1'b0, {47{1'b1}}}, TMAX - 3);
      send_cmd(dtpq_pkg::CMD_SCHED_AFTER, 16'h00cc, 1, 0, {1'b1, {47{1'b0}}}, 48'd7);
      send_cmd(dtpq_pkg::CMD_SCHED_AT, 16'h5555, 1, 48'd1000, 0, 0);
      send_cmd(dtpq_pkg::CMD_QUERY, 0, 0, 0, 0, 48'd500);
      send_cmd(3'd5, 0, 0, 0, 0, 0);
      send_cmd(3'd7, 16'hffff, 1, TMAX, -1, TMAX);
      send_cmd(dtpq_pkg::CMD_DRAIN, 0, 0, 0, 0, 48'd1000);
      send_cmd(dtpq_pkg::CMD_QUERY, 0, 0, 0, 0, TMAX);
      send_cmd(dtpq_pkg::CMD_DRAIN, 0, 0, 0, 0, TMAX);
      wait_results_drained();
   endtask

   // fill past capacity while the receiver holds off
   task automatic test_full_and_backpressure();
      recv_hold = 1;
      fork
         begin repeat (400) @(posedge clock); recv_hold = 0; end
         for (int i = 0; i < CAP + 2; i++)
            send_cmd(dtpq_pkg::CMD_SCHED_AT, 16'($urandom), 1'b1,
                     TB'($urandom_range(50)), '0, '0);
      join
      send_cmd(dtpq_pkg::CMD_QUERY, 0, 0, 0, 0, 10);
      send_cmd(dtpq_pkg::CMD_DRAIN, 0, 0, 0, 0, 25);
      wait_results_drained();
   endtask

   // random mix of mostly schedules with drains, queries and some unknown commands
   task automatic test_random(int n);
      logic [TB-1:0] base;
      int c;
      for (int i = 0; i < n; i++) begin
         base = ($urandom_range(3) == 0) ? rand_time() : TB'($urandom_range(2000));
         c = $urandom_range(99);
         if (c < 40)
            send_cmd(dtpq_pkg::CMD_SCHED_AT, 16'($urandom), $urandom_range(9) != 0,
                     ($urandom_range(9) == 0) ? rand_time() : TB'($urandom_range(3000)),
                     '0, '0);
         else if (c < 65)
            send_cmd(dtpq_pkg::CMD_SCHED_AFTER, 16'($urandom), $urandom_range(9) != 0,
                     rand_time(),
                     ($urandom_range(3) == 0) ? rand_time()
                                              : TB'(int'($urandom_range(1000)) - 200),
                     base);
         else if (c < 82)
            send_cmd(dtpq_pkg::CMD_DRAIN, 16'($urandom), 1'($urandom), rand_time(), '0, base);
         else if (c < 97)
            send_cmd(dtpq_pkg::CMD_QUERY, 16'($urandom), 1'($urandom), rand_time(), '0, base);
         else
            send_cmd(3'(5 + $urandom_range(2)), 16'($urandom), 1'($urandom), '0, '0, '0);
         if (i % 60 == 59) wait_results_drained();
      end
      wait_results_drained();
   endtask

   // cancel all, then refused schedules, a query and a repeated cancel
   task automatic test_cancel();
      send_cmd(dtpq_pkg::CMD_CANCEL, 0, 0, 0, 0, 0);
      send_cmd(dtpq_pkg::CMD_SCHED_AT, 16'h0042, 1, 48'd5, 0, 0);
      send_cmd(dtpq_pkg::CMD_SCHED_AFTER, 16'h0043, 1, 0, 48'sd5, 48'd5);
      send_cmd(dtpq_pkg::CMD_QUERY, 0, 0, 0, 0, 0);
      send_cmd(dtpq_pkg::CMD_CANCEL, 0, 0, 0, 0, 0);
      wait_results_drained();
   endtask

   initial begin
      req_ch.valid = 0; req_ch.cmd = 0; req_ch.handle_id = 0; req_ch.handle_live = 0;
      req_ch.deadline = 0; req_ch.delay = 0; req_ch.now = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_full_and_backpressure();
      send_idle_pct = 7; recv_idle_pct = 66;
      test_random(130);
      send_idle_pct = 66; recv_idle_pct = 7;
      test_random(110);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(60);
      test_cancel();
      if (expected_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_results.size());
         errors++;
      end
      $display("covered %0d command beats and %0d result beats: schedules, drains,",
               req_beats, rsp_beats);
      $display("queries, full queue, back-pressure and cancel; %0d errors", errors);
      if (errors == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end
endmodule
